FILE: rtl/core/rgbc_pkg.sv
// Shared types, constants and codes for the RGB 3x3 convolution filter.
`timescale 1ns / 1ps
`default_nettype none
package rgbc_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	localparam int CHAN_W    = 8;
	localparam int PIX_W     = 3 * CHAN_W;
	localparam int NUM_LANES = 3;
	localparam int WIN_TAPS  = 9;
	localparam int OUT_POS_W = 11;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 48;

	localparam int MODE_W  = 2;
	localparam int WIDTH_W = 12;
	localparam int CFG_W   = 12;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b1;

	localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLUR  = 2'd1;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd640;
	localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_EDGE;

	// 0.11 in Q16
	localparam logic [12:0] BLUR_Q16 = 13'd7209;

	// output queue
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [WIN_TAPS-1:0][CHAN_W-1:0] win_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0] col;
		logic [OUT_POS_W-1:0] row;
		logic                 last;
	} pos_meta_t;

endpackage
`default_nettype wire

FILE: rtl/core/rgbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rgbc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/rgbc_lane.sv
// One color channel of the 3x3 filter: window sums, kernel select and clamp.
`timescale 1ns / 1ps
`default_nettype none
module rgbc_lane (
	input  wire logic                       clk,
	input  wire logic [rgbc_pkg::MODE_W-1:0] mode,
	input  wire rgbc_pkg::win_t             win,
	output rgbc_pkg::chan_t                 result
);

	logic [11:0] sum9;
	logic [9:0]  cross4;
	logic [11:0] sum9_s3;
	logic [9:0]  cross4_s3;
	logic [7:0]  centre_s3;

	logic [11:0]        c9;
	logic [10:0]        c5;
	logic signed [12:0] acc_edge;
	logic signed [12:0] acc_sharp;
	logic [23:0]        prod;
	rgbc_pkg::chan_t    res_d;

	function automatic rgbc_pkg::chan_t clamp8(input logic signed [12:0] v);
		rgbc_pkg::chan_t r;
		if (v < 0) begin
			r = '0;
		end else if (v > 13'sd255) begin
			r = 8'hFF;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	always_comb begin
		sum9 = '0;
		for (int t = 0; t < rgbc_pkg::WIN_TAPS; t++) begin
			sum9 = sum9 + 12'(win[t]);
		end
		cross4 = 10'(win[1]) + 10'(win[3]) + 10'(win[5]) + 10'(win[7]);
	end

	always_ff @(posedge clk) begin
		sum9_s3   <= sum9;
		cross4_s3 <= cross4;
		centre_s3 <= win[4];
	end

	always_comb begin
		c9        = {1'b0, centre_s3, 3'b000} + 12'(centre_s3);
		c5        = {1'b0, centre_s3, 2'b00} + 11'(centre_s3);
		acc_edge  = $signed({1'b0, c9}) - $signed({1'b0, sum9_s3});
		acc_sharp = $signed({2'b00, c5}) - $signed({3'b000, cross4_s3});
		prod      = 24'(sum9_s3) * 24'(rgbc_pkg::BLUR_Q16);
		case (mode)
			rgbc_pkg::MODE_EDGE: res_d = clamp8(acc_edge);
			rgbc_pkg::MODE_BLUR: res_d = prod[23:16];
			default:             res_d = clamp8(acc_sharp);
		endcase
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

endmodule
`default_nettype wire

FILE: rtl/core/rgbc_merge.sv
// Merge of the three lane results with position into the output word queue.
`timescale 1ns / 1ps
`default_nettype none
module rgbc_merge (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	input  rgbc_pkg::chan_t                            lane_res [rgbc_pkg::NUM_LANES],
	input  rgbc_pkg::pos_meta_t                        meta,
	output logic [rgbc_pkg::OQ_AW:0]                   level,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [rgbc_pkg::M_TDATA_W-1:0]             m_tdata,
	output logic                                       m_tlast
);

	localparam int ENTRY_W = 3 * rgbc_pkg::CHAN_W + 2 * rgbc_pkg::OUT_POS_W + 1;

	logic [ENTRY_W-1:0]          entry_q [rgbc_pkg::OQ_DEPTH];
	logic [rgbc_pkg::OQ_AW-1:0]  wptr_q;
	logic [rgbc_pkg::OQ_AW-1:0]  rptr_q;
	logic [rgbc_pkg::OQ_AW:0]    count_q;
	logic                        pop;
	logic [ENTRY_W-1:0]          head;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (count_q != '0);
	assign level    = count_q;
	assign head     = entry_q[rptr_q];
	assign m_tlast  = head[ENTRY_W-1];
	assign m_tdata  = {{(rgbc_pkg::M_TDATA_W - ENTRY_W + 1){1'b0}}, head[ENTRY_W-2:0]};

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= {meta.last, meta.row, meta.col,
			                    lane_res[2], lane_res[1], lane_res[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rgb_conv3x3_filter.sv
// Top level of the streaming RGB 3x3 convolution filter.
// Pixels enter in raster order, one word per clock while s_tready is high, and
// each pixel at column >= 2 and row >= 2 completes the window centred one
// column and one row back; that window is filtered per channel by three
// side-by-side lanes with the kernel that effect_mode selects (0 edge detect,
// 1 box blur, 2 and 3 sharpen), clamped to 0..255, and sent out with its
// centre position. Border pixels give no output word. A result is registered
// in turn at the line memory read, the window shift, the lane sums and the
// kernel and clamp before it reaches the output queue. The line memory has
// one read and one write port, so one pixel per clock is the peak rate. An
// eight-word output queue parts the two sides; s_tready drops only while
// queued words plus results still in flight could fill it.
// The line memory is not cleared after reset: every read that feeds an output
// hits an entry written earlier in the frame, so no clearing pass is needed.
// Write configuration only while the block is idle; a write takes effect at once.
`timescale 1ns / 1ps
`default_nettype none
module rgb_conv3x3_filter #(
	parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write port
	input  wire logic                                 cfg_we,
	input  wire logic [rgbc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rgbc_pkg::CFG_W-1:0]           cfg_wdata,
	// pixel input
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [rgbc_pkg::S_TDATA_W-1:0]       s_tdata,  // red_in, green_in, blue_in
	input  wire logic                                 s_tlast,  // frame_last
	// filtered output
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [rgbc_pkg::M_TDATA_W-1:0]            m_tdata,  // red_out, green_out,
	                                                            // blue_out, out_col, out_row
	output logic                                      m_tlast   // frame_done
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (WW > rgbc_pkg::WIDTH_W) ? WW : rgbc_pkg::WIDTH_W;
	localparam int PW   = rgbc_pkg::PIX_W;
	localparam int POSW = rgbc_pkg::OUT_POS_W;

	// configuration registers
	logic [rgbc_pkg::MODE_W-1:0]  effect_mode_q;
	logic [rgbc_pkg::WIDTH_W-1:0] image_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mode_q <= rgbc_pkg::MODE_RESET;
			image_width_q <= rgbc_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rgbc_pkg::REG_EFFECT_MODE: effect_mode_q <= cfg_wdata[rgbc_pkg::MODE_W-1:0];
				rgbc_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg_wdata[rgbc_pkg::WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective width: clamp into 3..MAX_WIDTH, then take the last column
	logic [CMPW-1:0] width_ext;
	logic [CMPW-1:0] width_eff;
	logic [CW-1:0]   last_col;

	always_comb begin
		width_ext = CMPW'(image_width_q);
		if (width_ext < CMPW'(3)) begin
			width_eff = CMPW'(3);
		end else if (width_ext > CMPW'(MAX_WIDTH)) begin
			width_eff = CMPW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		last_col = CW'(width_eff - CMPW'(1));
	end

	// position counters, stage 0 (accept)
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col;
	logic          accept;
	logic          emit;
	logic [CW-1:0] col_m1;
	logic [RW-1:0] row_m1;
	logic [rgbc_pkg::OQ_AW:0] oq_level;
	logic [rgbc_pkg::OQ_AW+1:0] credit_use;

	assign accept = s_tvalid && s_tready;
	assign col    = (col_q > last_col) ? last_col : col_q;
	assign emit   = (row_q >= RW'(2)) && (col >= CW'(2));
	assign col_m1 = col - CW'(1);
	assign row_m1 = row_q - RW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col >= last_col) begin
				col_q <= '0;
				row_q <= (row_q == RW'(MAX_HEIGHT - 1)) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col + CW'(1);
			end
		end
	end

	// pipeline control: v_s1 moves the window, e_sN marks words that will emit
	logic v_s1;
	logic e_s1, e_s2, e_s3, e_s4;

	// hold input while queued words plus emitting words in flight could fill the queue
	assign credit_use = (rgbc_pkg::OQ_AW + 2)'(oq_level)
	                  + (rgbc_pkg::OQ_AW + 2)'(e_s1) + (rgbc_pkg::OQ_AW + 2)'(e_s2)
	                  + (rgbc_pkg::OQ_AW + 2)'(e_s3) + (rgbc_pkg::OQ_AW + 2)'(e_s4);
	assign s_tready   = credit_use < (rgbc_pkg::OQ_AW + 2)'(rgbc_pkg::OQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			e_s1 <= 1'b0;
			e_s2 <= 1'b0;
			e_s3 <= 1'b0;
			e_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			e_s1 <= accept && emit;
			e_s2 <= e_s1;
			e_s3 <= e_s2;
			e_s4 <= e_s3;
		end
	end

	// payload pipeline
	logic [PW-1:0]       px_s1;
	logic [CW-1:0]       col_s1;
	rgbc_pkg::pos_meta_t meta_s1, meta_s2, meta_s3, meta_s4;

	always_ff @(posedge clk) begin
		px_s1        <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
		col_s1       <= col;
		meta_s1.col  <= POSW'(col_m1);
		meta_s1.row  <= POSW'(row_m1);
		meta_s1.last <= s_tlast;
		meta_s2      <= meta_s1;
		meta_s3      <= meta_s2;
		meta_s4      <= meta_s3;
	end

	// line memory: each column holds {two rows back, one row back}
	logic [2*PW-1:0] ram_rdata;
	logic [2*PW-1:0] line_s1;
	logic [2*PW-1:0] byp_data_q;
	logic            byp_q;

	rgbc_ram #(
		.WIDTH (2 * PW),
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_ram (
		.clk   (clk),
		.we    (v_s1),
		.waddr (col_s1),
		.wdata ({line_s1[PW-1:0], px_s1}),
		.raddr (col),
		.rdata (ram_rdata)
	);

	// forward the write in flight when the next pixel reads the same column
	assign line_s1 = byp_q ? byp_data_q : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= v_s1 && (col_s1 == col);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= {line_s1[PW-1:0], px_s1};
	end

	// 3x3 window, tap = row * 3 + column, row 0 the oldest line
	logic [rgbc_pkg::WIN_TAPS-1:0][PW-1:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= win_q[r*3 + 1];
				win_q[r*3 + 1] <= win_q[r*3 + 2];
			end
			win_q[2] <= line_s1[2*PW-1:PW];
			win_q[5] <= line_s1[PW-1:0];
			win_q[8] <= px_s1;
		end
	end

	// one lane per channel: lane 0 red, 1 green, 2 blue
	rgbc_pkg::win_t  lane_win [rgbc_pkg::NUM_LANES];
	rgbc_pkg::chan_t lane_res [rgbc_pkg::NUM_LANES];

	always_comb begin
		for (int g = 0; g < rgbc_pkg::NUM_LANES; g++) begin
			for (int t = 0; t < rgbc_pkg::WIN_TAPS; t++) begin
				lane_win[g][t] = win_q[t][rgbc_pkg::CHAN_W*(2-g) +: rgbc_pkg::CHAN_W];
			end
		end
	end

	for (genvar g = 0; g < rgbc_pkg::NUM_LANES; g++) begin : g_lane
		rgbc_lane u_lane (
			.clk    (clk),
			.mode   (effect_mode_q),
			.win    (lane_win[g]),
			.result (lane_res[g])
		);
	end

	// merge lanes with position into the output queue
	rgbc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (e_s4),
		.lane_res (lane_res),
		.meta     (meta_s4),
		.level    (oq_level),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

FILE: bench/rgb_conv3x3_filter_test.sv
// Self-checking bench for the 3x3 RGB convolution filter, with a directed table and frames
`timescale 1ns / 1ps
module rgb_conv3x3_filter_test;

	// Modes two and three both select the sharpen kernel.
	localparam logic [rgbc_pkg::MODE_W-1:0] MODE_SHARP     = 2'd2;
	localparam logic [rgbc_pkg::MODE_W-1:0] MODE_SHARP_ALT = 2'd3;
	// Quiet cycles after the last result before the block counts as idle.
	localparam int HOLD_CYCLES    = 8;
	localparam int RANDOM_PIXELS  = 600;
	localparam int WIDE_PIXELS    = 24;

	typedef struct packed {
		rgbc_pkg::chan_t red;
		rgbc_pkg::chan_t green;
		rgbc_pkg::chan_t blue;
	} rgb_t;

	typedef struct packed {
		rgbc_pkg::chan_t                red;
		rgbc_pkg::chan_t                green;
		rgbc_pkg::chan_t                blue;
		logic [rgbc_pkg::OUT_POS_W-1:0] col;
		logic [rgbc_pkg::OUT_POS_W-1:0] row;
		logic                           done;
	} filt_word_t;

	// One row of the directed table: a register write or a pixel, with an
	// optional typed-in result that replaces the predicted one.
	typedef struct {
		bit                             is_cfg;
		logic [rgbc_pkg::CFG_IDX_W-1:0] idx;
		logic [rgbc_pkg::CFG_W-1:0]     value;
		rgb_t                           px;
		bit                             last;
		bit                             typed;
		filt_word_t                     want;
	} plan_row_t;

	localparam rgb_t GREEN_PX = {8'd0, 8'd255, 8'd0};
	localparam rgb_t RED_PX   = {8'd255, 8'd0, 8'd0};
	localparam rgb_t WHITE_PX = {8'd255, 8'd255, 8'd255};
	localparam rgb_t BLACK_PX = {8'd0, 8'd0, 8'd0};
	localparam rgb_t MIXED_PX = {8'd10, 8'd200, 8'd90};

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [rgbc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rgbc_pkg::CFG_W-1:0]     cfg_wdata;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [rgbc_pkg::S_TDATA_W-1:0] s_tdata;   // red_in, green_in, blue_in
	logic                           s_tlast;   // frame_last
	logic                           m_tvalid;
	logic                           m_tready;
	logic [rgbc_pkg::M_TDATA_W-1:0] m_tdata;   // red_out, green_out, blue_out, out_col, out_row
	logic                           m_tlast;   // frame_done

	rgb_conv3x3_filter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Predictor state: two previous rows, the 3x3 window, raster position
	// and the two registers as the block should hold them.
	rgb_t                         line_prev[rgbc_pkg::MAX_WIDTH_DEF];
	rgb_t                         line_prev2[rgbc_pkg::MAX_WIDTH_DEF];
	rgb_t                         tap[3][3];
	int                           col_pos;
	int                           row_pos;
	logic [rgbc_pkg::MODE_W-1:0]  kernel_sel;
	logic [rgbc_pkg::WIDTH_W-1:0] row_len_reg;

	filt_word_t awaited_words[$];
	plan_row_t  test_plan[$];
	int         errors;
	int         pixels_sent;
	bit         calm;   // no gaps and no stalls while set

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Effective row length: the block clamps the register to 3..MAX_WIDTH.
	function automatic int row_len();
		int w;
		w = row_len_reg;
		if (w < 3)
			w = 3;
		if (w > rgbc_pkg::MAX_WIDTH_DEF)
			w = rgbc_pkg::MAX_WIDTH_DEF;
		return w;
	endfunction

	function automatic rgbc_pkg::chan_t lane(rgb_t p, int k);
		case (k)
			0: return p.red;
			1: return p.green;
			default: return p.blue;
		endcase
	endfunction

	// Apply the selected kernel to one channel of the window and clamp.
	function automatic rgbc_pkg::chan_t convolve_lane(int k);
		int sum9;
		int cross4;
		int centre;
		int acc;
		int r;
		int c;
		sum9 = 0;
		for (r = 0; r < 3; r++)
			for (c = 0; c < 3; c++)
				sum9 += lane(tap[r][c], k);
		cross4 = lane(tap[0][1], k) + lane(tap[2][1], k) + lane(tap[1][0], k)
			+ lane(tap[1][2], k);
		centre = lane(tap[1][1], k);
		if (kernel_sel == rgbc_pkg::MODE_EDGE)
			acc = 9 * centre - sum9;
		else if (kernel_sel == rgbc_pkg::MODE_BLUR)
			acc = (sum9 * int'(rgbc_pkg::BLUR_Q16)) >>> 16;
		else
			acc = 5 * centre - cross4;
		if (acc < 0)
			acc = 0;
		if (acc > 255)
			acc = 255;
		return rgbc_pkg::chan_t'(acc);
	endfunction

	// Advance the window by one pixel; return 1 and the word when it
	// completes an interior window.
	function automatic bit filter_pixel(rgb_t px, bit last, output filt_word_t res);
		int  w;
		int  col;
		int  r;
		bit  hit;
		w = row_len();
		col = col_pos;
		// A width shrunk mid-row pins the column to the new row end.
		if (col >= w)
			col = w - 1;
		for (r = 0; r < 3; r++) begin
			tap[r][0] = tap[r][1];
			tap[r][1] = tap[r][2];
		end
		tap[0][2] = line_prev2[col];
		tap[1][2] = line_prev[col];
		tap[2][2] = px;
		line_prev2[col] = line_prev[col];
		line_prev[col] = px;
		hit = (row_pos >= 2) && (col >= 2);
		res = '0;
		if (hit) begin
			res.red   = convolve_lane(0);
			res.green = convolve_lane(1);
			res.blue  = convolve_lane(2);
			res.col   = (rgbc_pkg::OUT_POS_W)'(col - 1);
			res.row   = (rgbc_pkg::OUT_POS_W)'(row_pos - 1);
			res.done  = last;
		end
		if (last) begin
			col_pos = 0;
			row_pos = 0;
		end else if (col + 1 >= w) begin
			col_pos = 0;
			// Rows past the height limit wrap back to the first row.
			row_pos = (row_pos + 1 >= rgbc_pkg::MAX_HEIGHT_DEF) ? 0 : row_pos + 1;
		end else begin
			col_pos = col + 1;
		end
		return hit;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// Bias channels toward the extremes so both clamps get hit.
	function automatic rgbc_pkg::chan_t rand_chan();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return rgbc_pkg::chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic rgb_t rand_px();
		rgb_t p;
		p.red   = rand_chan();
		p.green = rand_chan();
		p.blue  = rand_chan();
		return p;
	endfunction

	function automatic void plan_cfg(logic [rgbc_pkg::CFG_IDX_W-1:0] idx,
		logic [rgbc_pkg::CFG_W-1:0] value);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.value = value;
		test_plan.push_back(row);
	endfunction

	function automatic void plan_px(rgb_t px, bit last);
		plan_row_t row;
		row = '{default: '0};
		row.px = px;
		row.last = last;
		test_plan.push_back(row);
	endfunction

	function automatic void plan_chk(rgb_t px, filt_word_t want);
		plan_row_t row;
		row = '{default: '0};
		row.px = px;
		row.typed = 1'b1;
		row.want = want;
		test_plan.push_back(row);
	endfunction

	// Offer one pixel word, hold it until taken, then log the expected result.
	task automatic send_pixel(rgb_t px, bit last, bit typed, filt_word_t want);
		filt_word_t res;
		int         gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {px.blue, px.green, px.red};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pixels_sent++;
		if (filter_pixel(px, last, res))
			awaited_words.push_back(typed ? want : res);
	endtask

	// Drop valid and wait until every expected word is out and the pipe is empty.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [rgbc_pkg::CFG_IDX_W-1:0] idx,
		logic [rgbc_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rgbc_pkg::REG_EFFECT_MODE)
			kernel_sel = value[rgbc_pkg::MODE_W-1:0];
		else
			row_len_reg = value[rgbc_pkg::WIDTH_W-1:0];
		@(posedge clk);
	endtask

	// One random frame starting at the top-left corner. A broken frame ends
	// early on a random pixel; a paused frame stops once mid-frame, may change
	// the mode, and shrinks or keeps the width (never grows it, so that no window
	// reads a line entry that was never written).
	task automatic run_frame(int rows, bit broken, bit pause);
		int         cut;
		int         pause_at;
		int         sent;
		int         w;
		int         col;
		bit         last;
		filt_word_t none;
		cut = broken ? $urandom_range(1, rows * row_len()) : 0;
		pause_at = pause ? $urandom_range(1, rows * row_len()) : -1;
		sent = 0;
		last = 1'b0;
		none = '0;
		while (!last) begin
			if (sent == pause_at) begin
				drain();
				if ($urandom_range(0, 1))
					write_reg(rgbc_pkg::REG_EFFECT_MODE,
						(rgbc_pkg::CFG_W)'($urandom_range(0, 3)));
				write_reg(rgbc_pkg::REG_IMAGE_WIDTH,
					(rgbc_pkg::CFG_W)'($urandom_range(0, row_len())));
			end
			w = row_len();
			col = (col_pos < w) ? col_pos : w - 1;
			last = (row_pos == rows - 1 && col == w - 1) || (sent + 1 == cut);
			send_pixel(rand_px(), last, 1'b0, none);
			sent++;
		end
	endtask

	task automatic compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Output side: check each taken word against the oldest expectation and
	// throttle m_tready with random stalls.
	initial begin
		int         stall_left;
		filt_word_t got;
		filt_word_t want;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.red   = m_tdata[0 +: rgbc_pkg::CHAN_W];
				got.green = m_tdata[rgbc_pkg::CHAN_W +: rgbc_pkg::CHAN_W];
				got.blue  = m_tdata[2 * rgbc_pkg::CHAN_W +: rgbc_pkg::CHAN_W];
				got.col   = m_tdata[3 * rgbc_pkg::CHAN_W +: rgbc_pkg::OUT_POS_W];
				got.row   = m_tdata[3 * rgbc_pkg::CHAN_W + rgbc_pkg::OUT_POS_W
					+: rgbc_pkg::OUT_POS_W];
				got.done  = m_tlast;
				if (awaited_words.size() == 0) begin
					$error("output word with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					want = awaited_words.pop_front();
					compare_field("red_out", want.red, got.red);
					compare_field("green_out", want.green, got.green);
					compare_field("blue_out", want.blue, got.blue);
					compare_field("out_col", want.col, got.col);
					compare_field("out_row", want.row, got.row);
					compare_field("frame_done", want.done, got.done);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Stimulus.
	initial begin
		int         i;
		int         start;
		int         total;
		filt_word_t none;
		errors = 0;
		pixels_sent = 0;
		calm = 1'b0;
		none = '0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		kernel_sel  = rgbc_pkg::MODE_RESET;
		row_len_reg = rgbc_pkg::WIDTH_RESET;
		col_pos = 0;
		row_pos = 0;
		tap = '{default: '0};
		for (i = 0; i < rgbc_pkg::MAX_WIDTH_DEF; i++) begin
			line_prev[i]  = '0;
			line_prev2[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frame, three pixels per row so each row from the third on
		// yields one word. A width of 1 must act as 3.
		plan_cfg(rgbc_pkg::REG_IMAGE_WIDTH, 12'd1);
		plan_cfg(rgbc_pkg::REG_EFFECT_MODE, (rgbc_pkg::CFG_W)'(rgbc_pkg::MODE_EDGE));
		plan_px(GREEN_PX, 1'b0); plan_px(GREEN_PX, 1'b0); plan_px(GREEN_PX, 1'b0);
		plan_px(GREEN_PX, 1'b0); plan_px(RED_PX, 1'b0);   plan_px(GREEN_PX, 1'b0);
		plan_px(GREEN_PX, 1'b0); plan_px(GREEN_PX, 1'b0);
		// Red centre in green: edge pushes red past 255 and green below 0.
		plan_chk(GREEN_PX, {8'd255, 8'd0, 8'd0, 11'd1, 11'd1, 1'b0});
		plan_cfg(rgbc_pkg::REG_EFFECT_MODE, (rgbc_pkg::CFG_W)'(MODE_SHARP));
		plan_px(GREEN_PX, 1'b0); plan_px(GREEN_PX, 1'b0);
		// Sharpen on a green centre with a red neighbour above.
		plan_chk(GREEN_PX, {8'd0, 8'd255, 8'd0, 11'd1, 11'd2, 1'b0});
		// Mode three decodes as sharpen.
		plan_cfg(rgbc_pkg::REG_EFFECT_MODE, (rgbc_pkg::CFG_W)'(MODE_SHARP_ALT));
		plan_px(MIXED_PX, 1'b0); plan_px(WHITE_PX, 1'b0); plan_px(MIXED_PX, 1'b0);
		plan_cfg(rgbc_pkg::REG_EFFECT_MODE, (rgbc_pkg::CFG_W)'(rgbc_pkg::MODE_BLUR));
		plan_px(WHITE_PX, 1'b0); plan_px(WHITE_PX, 1'b0); plan_px(WHITE_PX, 1'b1);
		// A frame end that completes no window gives no word at all.
		plan_px(BLACK_PX, 1'b1);
		foreach (test_plan[k]) begin
			if (test_plan[k].is_cfg) begin
				drain();
				write_reg(test_plan[k].idx, test_plan[k].value);
			end else begin
				send_pixel(test_plan[k].px, test_plan[k].last, test_plan[k].typed,
					test_plan[k].want);
			end
		end
		drain();

		// Widest setting: an all-ones width acts as MAX_WIDTH, so a short frame
		// stays on the first row and gives no word.
		write_reg(rgbc_pkg::REG_EFFECT_MODE, (rgbc_pkg::CFG_W)'($urandom_range(0, 3)));
		write_reg(rgbc_pkg::REG_IMAGE_WIDTH, 12'hFFF);
		total = WIDE_PIXELS;
		for (i = 0; i < total; i++)
			send_pixel(rand_px(), i == total - 1, 1'b0, none);
		drain();

		// Random frames: mostly whole frames, some cut short, some paused.
		start = pixels_sent;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) begin
				drain();
				if ($urandom_range(0, 1))
					write_reg(rgbc_pkg::REG_EFFECT_MODE,
						(rgbc_pkg::CFG_W)'($urandom_range(0, 3)));
				case ($urandom_range(0, 9))
					0: write_reg(rgbc_pkg::REG_IMAGE_WIDTH,
						(rgbc_pkg::CFG_W)'($urandom_range(0, 2)));
					1, 2: write_reg(rgbc_pkg::REG_IMAGE_WIDTH,
						(rgbc_pkg::CFG_W)'($urandom_range(13, 64)));
					default: write_reg(rgbc_pkg::REG_IMAGE_WIDTH,
						(rgbc_pkg::CFG_W)'($urandom_range(3, 12)));
				endcase
			end
			run_frame($urandom_range(1, 6), $urandom_range(0, 4) == 0,
				$urandom_range(0, 3) == 0);
		end
		calm = 1'b0;
		drain();

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/rgbc_pkg.sv
rtl/core/rgbc_ram.sv
rtl/core/rgbc_lane.sv
rtl/core/rgbc_merge.sv
rtl/core/rgb_conv3x3_filter.sv
bench/rgb_conv3x3_filter_test.sv
